### design/multi_slot_timer_table_unit_defines.svh
// Assertion macros shared by the checker of the timer table unit.
// Depends on nothing; the including scope must provide clk and rst_n.
`ifndef MULTI_SLOT_TIMER_TABLE_UNIT_DEFINES_SVH
`define MULTI_SLOT_TIMER_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MSTT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define MSTT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/mstt_pkg.sv
// Package of the timer table unit: operation and status codes, the slot word
// stored in memory and the result word. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package mstt_pkg;

    localparam int NUM_SLOTS_DEF = 64;
    localparam int MAX_FIRED     = 64;

    localparam logic [30:0] WAIT_MAX = 31'h7FFF_FFFF;

    // Operation codes.
    localparam logic [2:0] OP_CREATE_ONE = 3'd0;
    localparam logic [2:0] OP_CREATE_REP = 3'd1;
    localparam logic [2:0] OP_CANCEL     = 3'd2;
    localparam logic [2:0] OP_QUERY      = 3'd3;
    localparam logic [2:0] OP_NEXT_WAIT  = 3'd4;
    localparam logic [2:0] OP_PROCESS    = 3'd5;

    // Status codes.
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_BAD_IVL     = 3'd1;
    localparam logic [2:0] ST_NO_FREE     = 3'd2;
    localparam logic [2:0] ST_NOT_ACTIVE  = 3'd3;
    localparam logic [2:0] ST_NONE_ACTIVE = 3'd4;

    // One slot entry as kept in memory.
    typedef struct packed {
        logic        repeats;
        logic [31:0] interval;
        logic [48:0] expiry;
    } slot_word_t;

    // One result word.
    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  slot_index;
        logic        fired;
        logic        is_active;
        logic [30:0] wait_ms;
        logic [6:0]  fired_count;
        logic        last;
    } res_t;

endpackage

`default_nettype wire

### design/mstt_cmd_if.sv
// Command channel interface of the timer table unit.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface mstt_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [47:0] now_ms;
    logic [31:0] period_ms;
    logic [5:0]  handle;

    modport source (output valid, kind, now_ms, period_ms, handle, input ready);
    modport sink   (input valid, kind, now_ms, period_ms, handle, output ready);
endinterface

`default_nettype wire

### design/mstt_res_if.sv
// Result channel interface of the timer table unit.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface mstt_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [5:0]  slot_index;
    logic        fired;
    logic        is_active;
    logic [30:0] wait_ms;
    logic [6:0]  fired_count;
    logic        last;

    modport source (output valid, status, slot_index, fired, is_active, wait_ms,
                    fired_count, last, input ready);
    modport sink   (input valid, status, slot_index, fired, is_active, wait_ms,
                    fired_count, last, output ready);
endinterface

`default_nettype wire

### design/mstt_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module mstt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Read port; data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### design/multi_slot_timer_table_unit.sv
// Timer table: cancel, query and unused operations are settled in the idle state;
// the emit state then moves the result word into the output register once it is free.
// Create scans the active flags for the lowest free slot before its result.
// Next wait and process scan the slot memory with a read state and an evaluate
// state per slot, set by the one read port of the memory.
// One item is in work at a time. Reset clears all active flags at once.
`timescale 1ns / 1ps
`default_nettype none

module multi_slot_timer_table_unit
    import mstt_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
    input wire logic clk,
    input wire logic rst_n,
    mstt_cmd_if.sink   cmd,
    mstt_res_if.source res
);

    localparam int IDX_W = $clog2(NUM_SLOTS);
    localparam int CNT_W = $clog2(NUM_SLOTS + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FREE = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_EV   = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;
    localparam logic [2:0] S_EMIT = 3'd5;

    logic [2:0]           state_reg, state_next;
    logic [2:0]           op_reg, op_next;
    logic [47:0]          now_reg, now_next;
    logic [31:0]          ivl_reg, ivl_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic [6:0]           cnt_reg, cnt_next;
    logic                 found_reg, found_next;
    logic [48:0]          best_reg, best_next;
    logic                 hold_valid_reg, hold_valid_next;
    logic [5:0]           hold_slot_reg, hold_slot_next;
    res_t                 res_reg, res_next;
    res_t                 out_reg, out_next;
    logic                 out_valid_reg, out_valid_next;
    logic [NUM_SLOTS-1:0] active_reg, active_next;

    logic       mem_we, mem_re;
    logic [IDX_W-1:0] mem_waddr;
    slot_word_t mem_wdata, mem_rdata;

    logic [8:0]       h_ext;
    logic             h_ok;
    logic [IDX_W-1:0] cur;
    logic             out_free;
    logic [48:0]      diff;
    logic             fire;

    mstt_ram #(
        .WIDTH ($bits(slot_word_t)),
        .DEPTH (NUM_SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (cur),
        .rdata (mem_rdata)
    );

    assign h_ext    = {3'b000, cmd.handle};
    assign h_ok     = h_ext < 9'(NUM_SLOTS);
    assign cur      = idx_reg[IDX_W-1:0];
    assign out_free = !out_valid_reg || res.ready;
    assign diff     = best_reg - {1'b0, now_reg};
    assign fire     = active_reg[cur] && (mem_rdata.expiry <= {1'b0, now_reg});

    assign cmd.ready = (state_reg == S_IDLE);

    // Sequencer: one operation at a time, memory read-modify-write per slot.
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        now_next        = now_reg;
        ivl_next        = ivl_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        found_next      = found_reg;
        best_next       = best_reg;
        hold_valid_next = hold_valid_reg;
        hold_slot_next  = hold_slot_reg;
        res_next        = res_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !res.ready;
        active_next     = active_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_waddr       = cur;
        mem_wdata       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    op_next    = cmd.kind;
                    now_next   = cmd.now_ms;
                    ivl_next   = cmd.period_ms;
                    idx_next   = '0;
                    cnt_next   = '0;
                    found_next = 1'b0;
                    hold_valid_next = 1'b0;
                    res_next      = '0;
                    res_next.last = 1'b1;
                    state_next    = S_EMIT;
                    case (cmd.kind)
                        OP_CREATE_ONE, OP_CREATE_REP:
                        begin
                            if (cmd.period_ms == 32'd0)
                            begin
                                res_next.status = ST_BAD_IVL;
                            end
                            else
                            begin
                                state_next = S_FREE;
                            end
                        end
                        OP_CANCEL:
                        begin
                            if (h_ok && active_reg[h_ext[IDX_W-1:0]])
                            begin
                                active_next[h_ext[IDX_W-1:0]] = 1'b0;
                            end
                            else
                            begin
                                res_next.status = ST_NOT_ACTIVE;
                            end
                        end
                        OP_QUERY:
                        begin
                            res_next.is_active = h_ok && active_reg[h_ext[IDX_W-1:0]];
                        end
                        OP_NEXT_WAIT, OP_PROCESS:
                        begin
                            state_next = S_RD;
                        end
                        default:
                        begin
                            state_next = S_EMIT;
                        end
                    endcase
                end
            end

            // Lowest free slot, one active flag per cycle.
            S_FREE:
            begin
                if (idx_reg == CNT_W'(NUM_SLOTS))
                begin
                    res_next.status = ST_NO_FREE;
                    state_next      = S_EMIT;
                end
                else if (!active_reg[cur])
                begin
                    active_next[cur]   = 1'b1;
                    mem_we             = 1'b1;
                    mem_wdata.repeats  = (op_reg == OP_CREATE_REP);
                    mem_wdata.interval = ivl_reg;
                    mem_wdata.expiry   = {1'b0, now_reg} + {17'd0, ivl_reg};
                    res_next.slot_index = 6'(idx_reg);
                    state_next          = S_EMIT;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            // Issue the read of the current slot or finish the scan.
            S_RD:
            begin
                if (idx_reg == CNT_W'(NUM_SLOTS) ||
                    (op_reg == OP_PROCESS && cnt_reg == 7'(MAX_FIRED)))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    state_next = S_EV;
                end
            end

            // Evaluate the slot word that came back from memory.
            S_EV:
            begin
                if (op_reg == OP_NEXT_WAIT)
                begin
                    if (active_reg[cur] && (!found_reg || mem_rdata.expiry < best_reg))
                    begin
                        best_next  = mem_rdata.expiry;
                        found_next = 1'b1;
                    end
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_RD;
                end
                else if (!fire)
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_RD;
                end
                else if (!hold_valid_reg || out_free)
                begin
                    // The held word is not the last one: push it out first.
                    if (hold_valid_reg)
                    begin
                        out_next             = '0;
                        out_next.slot_index  = hold_slot_reg;
                        out_next.fired       = 1'b1;
                        out_next.fired_count = cnt_reg;
                        out_valid_next       = 1'b1;
                    end
                    if (mem_rdata.repeats)
                    begin
                        mem_we           = 1'b1;
                        mem_wdata        = mem_rdata;
                        mem_wdata.expiry = {1'b0, now_reg} + {17'd0, mem_rdata.interval};
                    end
                    else
                    begin
                        active_next[cur] = 1'b0;
                    end
                    hold_valid_next = 1'b1;
                    hold_slot_next  = 6'(idx_reg);
                    cnt_next        = cnt_reg + 7'd1;
                    idx_next        = idx_reg + 1'b1;
                    state_next      = S_RD;
                end
            end

            // Final word of a scan.
            S_DONE:
            begin
                if (op_reg == OP_NEXT_WAIT)
                begin
                    if (!found_reg)
                    begin
                        res_next.status = ST_NONE_ACTIVE;
                    end
                    else if (best_reg > {1'b0, now_reg})
                    begin
                        res_next.wait_ms = (diff > {18'd0, WAIT_MAX}) ? WAIT_MAX
                                                                      : diff[30:0];
                    end
                end
                else if (hold_valid_reg)
                begin
                    res_next.slot_index  = hold_slot_reg;
                    res_next.fired       = 1'b1;
                    res_next.fired_count = cnt_reg;
                end
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            active_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            active_reg    <= active_next;
        end
    end

    // Payload and scan registers.
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        now_reg        <= now_next;
        ivl_reg        <= ivl_next;
        idx_reg        <= idx_next;
        cnt_reg        <= cnt_next;
        found_reg      <= found_next;
        best_reg       <= best_next;
        hold_valid_reg <= hold_valid_next;
        hold_slot_reg  <= hold_slot_next;
        res_reg        <= res_next;
        out_reg        <= out_next;
    end

    assign res.valid       = out_valid_reg;
    assign res.status      = out_reg.status;
    assign res.slot_index  = out_reg.slot_index;
    assign res.fired       = out_reg.fired;
    assign res.is_active   = out_reg.is_active;
    assign res.wait_ms     = out_reg.wait_ms;
    assign res.fired_count = out_reg.fired_count;
    assign res.last        = out_reg.last;

endmodule

`default_nettype wire

### design/mstt_checker.sv
// Port-level checker of the timer table unit and its bind to the top level.
// Depends on mstt_pkg and multi_slot_timer_table_unit_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "multi_slot_timer_table_unit_defines.svh"

module mstt_checker
    import mstt_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        cmd_ready,
    input wire logic        res_valid,
    input wire logic        res_ready,
    input wire logic [2:0]  res_status,
    input wire logic [5:0]  res_slot_index,
    input wire logic        res_fired,
    input wire logic        res_is_active,
    input wire logic [30:0] res_wait_ms,
    input wire logic        res_last
);

    // A stalled result word holds.
    `MSTT_ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_slot_index) && $stable(res_status) && $stable(res_last), "result word changed while stalled")

    // A pass that is not finished keeps new commands out.
    `MSTT_ASSERT_IMP(a_busy_mid_pass, res_valid && !res_last, !cmd_ready, "command taken during a processing pass")

    // A fired word carries nothing but its slot and count.
    `MSTT_ASSERT_IMP(a_fired_clean, res_valid && res_fired, res_status == ST_OK && !res_is_active && res_wait_ms == 31'd0, "fired word has stray fields")

    // An error ends the item at once.
    `MSTT_ASSERT_IMP(a_error_last, res_valid && res_status != ST_OK, res_last && !res_fired, "error word not final")

endmodule

bind multi_slot_timer_table_unit mstt_checker u_mstt_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_ready      (cmd.ready),
    .res_valid      (res.valid),
    .res_ready      (res.ready),
    .res_status     (res.status),
    .res_slot_index (res.slot_index),
    .res_fired      (res.fired),
    .res_is_active  (res.is_active),
    .res_wait_ms    (res.wait_ms),
    .res_last       (res.last)
);

`default_nettype wire

### tb/mstt_timer_checker.sv
// Checker of the timer table unit: watches both channels, keeps its own copy
// of the slot table and compares every result word with the predicted one.
// Depends on mstt_pkg and the channel interfaces mstt_cmd_if and mstt_res_if.
`timescale 1ns / 1ps

module mstt_timer_checker
    import mstt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    mstt_cmd_if  cmd,
    mstt_res_if  res,
    output int   mismatch_count,
    output int   results_pending
);

    // Shadow copy of the slot table.
    logic        slot_on [NUM_SLOTS_DEF];
    logic        slot_rep [NUM_SLOTS_DEF];
    logic [31:0] slot_period [NUM_SLOTS_DEF];
    logic [48:0] slot_due [NUM_SLOTS_DEF];

    res_t expected_words[$];

    assign results_pending = expected_words.size();

    function automatic res_t done_word(logic [2:0] st);
        res_t w;
        w = '0;
        w.status = st;
        w.last = 1'b1;
        return w;
    endfunction

    // Works out the result words of one accepted command word.
    task automatic predict_timer_op(logic [2:0] kind, logic [47:0] now,
                                    logic [31:0] ivl, logic [5:0] h);
        res_t w;
        res_t held;
        logic have_held;
        logic found;
        logic [48:0] best;
        logic [48:0] diff;
        int n;
        w = '0;
        held = '0;
        have_held = 1'b0;
        found = 1'b0;
        best = '0;
        diff = '0;
        n = 0;
        case (kind)
            OP_CREATE_ONE, OP_CREATE_REP:
            begin
                if (ivl == 32'd0) begin
                    expected_words.push_back(done_word(ST_BAD_IVL));
                end else begin
                    for (int i = 0; i < NUM_SLOTS_DEF; i++) begin
                        if (!found && !slot_on[i]) begin
                            found = 1'b1;
                            slot_on[i] = 1'b1;
                            slot_rep[i] = (kind == OP_CREATE_REP);
                            slot_period[i] = ivl;
                            slot_due[i] = {1'b0, now} + {17'd0, ivl};
                            w = done_word(ST_OK);
                            w.slot_index = i[5:0];
                        end
                    end
                    if (found)
                        expected_words.push_back(w);
                    else
                        expected_words.push_back(done_word(ST_NO_FREE));
                end
            end
            OP_CANCEL:
            begin
                if (slot_on[h]) begin
                    slot_on[h] = 1'b0;
                    expected_words.push_back(done_word(ST_OK));
                end else begin
                    expected_words.push_back(done_word(ST_NOT_ACTIVE));
                end
            end
            OP_QUERY:
            begin
                w = done_word(ST_OK);
                w.is_active = slot_on[h];
                expected_words.push_back(w);
            end
            OP_NEXT_WAIT:
            begin
                for (int i = 0; i < NUM_SLOTS_DEF; i++) begin
                    if (slot_on[i] && (!found || slot_due[i] < best)) begin
                        best = slot_due[i];
                        found = 1'b1;
                    end
                end
                if (!found) begin
                    expected_words.push_back(done_word(ST_NONE_ACTIVE));
                end else begin
                    w = done_word(ST_OK);
                    if (best > {1'b0, now}) begin
                        diff = best - {1'b0, now};
                        w.wait_ms = (diff > {18'd0, WAIT_MAX}) ? WAIT_MAX : diff[30:0];
                    end
                    expected_words.push_back(w);
                end
            end
            OP_PROCESS:
            begin
                // Each fired slot is held back one step so the final one gets last.
                for (int i = 0; i < NUM_SLOTS_DEF; i++) begin
                    if (n < MAX_FIRED && slot_on[i] && slot_due[i] <= {1'b0, now}) begin
                        if (slot_rep[i])
                            slot_due[i] = {1'b0, now} + {17'd0, slot_period[i]};
                        else
                            slot_on[i] = 1'b0;
                        if (have_held)
                            expected_words.push_back(held);
                        n++;
                        held = '0;
                        held.status = ST_OK;
                        held.slot_index = i[5:0];
                        held.fired = 1'b1;
                        held.fired_count = n[6:0];
                        have_held = 1'b1;
                    end
                end
                if (have_held) begin
                    held.last = 1'b1;
                    expected_words.push_back(held);
                end else begin
                    expected_words.push_back(done_word(ST_OK));
                end
            end
            default:
            begin
                expected_words.push_back(done_word(ST_OK));
            end
        endcase
    endtask

    task automatic check_field(string name, longint unsigned want, longint unsigned got);
        if (want != got) begin
            $error("field %s: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // Prediction on accepted commands, comparison on accepted results.
    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n) begin
            for (int i = 0; i < NUM_SLOTS_DEF; i++)
                slot_on[i] = 1'b0;
            expected_words.delete();
        end else begin
            if (cmd.valid && cmd.ready)
                predict_timer_op(cmd.kind, cmd.now_ms, cmd.period_ms, cmd.handle);
            if (res.valid && res.ready) begin
                if (expected_words.size() == 0) begin
                    $error("result word with no expected word waiting");
                    mismatch_count++;
                end else begin
                    want = expected_words.pop_front();
                    check_field("status", want.status, res.status);
                    check_field("slot_index", want.slot_index, res.slot_index);
                    check_field("fired", want.fired, res.fired);
                    check_field("is_active", want.is_active, res.is_active);
                    check_field("wait_ms", want.wait_ms, res.wait_ms);
                    check_field("fired_count", want.fired_count, res.fired_count);
                    check_field("last", want.last, res.last);
                end
            end
        end
    end

    initial mismatch_count = 0;

endmodule

### tb/testbench.sv
// Top of the timer table testbench: clock, reset, command stimulus with
// random gaps and result back-pressure, and the final verdict.
// Depends on mstt_pkg, the channel interfaces, the unit and mstt_timer_checker.
`timescale 1ns / 1ps

module testbench;
    import mstt_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int RANDOM_WORDS = 370;

    logic clk;
    logic rst_n;
    int   mismatch_count;
    int   results_pending;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   cycle_count;
    logic [47:0] clock_ms;

    mstt_cmd_if cmd ();
    mstt_res_if res ();

    multi_slot_timer_table_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .res   (res)
    );

    mstt_timer_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .res             (res),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    always #5 clk = ~clk;

    // Random back-pressure on the result side.
    always @(posedge clk)
    begin
        res.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Run guard.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Sends one command word after a random gap; returns right after acceptance.
    task automatic send_word(logic [2:0] kind, logic [47:0] now, logic [31:0] ivl,
                             logic [5:0] h);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 40)
            gap++;
        if (gap > 0) begin
            cmd.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd.valid     <= 1'b1;
        cmd.kind      <= kind;
        cmd.now_ms    <= now;
        cmd.period_ms <= ivl;
        cmd.handle    <= h;
        do @(posedge clk); while (!cmd.ready);
    endtask

    function automatic logic [31:0] pick_interval();
        int r;
        r = $urandom_range(99);
        if (r < 5)
            return 32'd0;
        else if (r < 12)
            return $urandom();
        else
            return $urandom_range(300, 1);
    endfunction

    // Random part: fill bursts followed by a late process, mixed with single operations.
    task automatic random_phase(int words);
        int sent;
        int burst;
        int r;
        sent = 0;
        while (sent < words) begin
            clock_ms = clock_ms + $urandom_range(60);
            r = $urandom_range(99);
            if (r < 12) begin
                burst = $urandom_range(70, 8);
                for (int i = 0; i < burst; i++) begin
                    send_word($urandom_range(1) ? OP_CREATE_REP : OP_CREATE_ONE,
                              clock_ms, $urandom_range(50, 1), 6'($urandom()));
                    clock_ms = clock_ms + $urandom_range(2);
                end
                clock_ms = clock_ms + $urandom_range(200, 40);
                send_word(OP_PROCESS, clock_ms, $urandom(), 6'($urandom()));
                sent += burst + 1;
            end else begin
                if (r < 40)
                    send_word($urandom_range(1) ? OP_CREATE_REP : OP_CREATE_ONE,
                              clock_ms, pick_interval(), 6'($urandom()));
                else if (r < 55)
                    send_word(OP_CANCEL, clock_ms, $urandom(), 6'($urandom_range(63)));
                else if (r < 65)
                    send_word(OP_QUERY, clock_ms, $urandom(), 6'($urandom_range(63)));
                else if (r < 77)
                    send_word(OP_NEXT_WAIT, clock_ms, $urandom(), 6'($urandom()));
                else if (r < 95)
                    send_word(OP_PROCESS, clock_ms, $urandom(), 6'($urandom()));
                else if (r < 97)
                    send_word(3'($urandom_range(7, 6)), clock_ms, $urandom(),
                              6'($urandom()));
                else
                    send_word(3'($urandom_range(5)), {$urandom(), 16'($urandom())},
                              $urandom(), 6'($urandom()));
                sent++;
            end
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cycle_count = 0;
        cmd.valid = 1'b0;
        cmd.kind = OP_QUERY;
        cmd.now_ms = '0;
        cmd.period_ms = '0;
        cmd.handle = '0;
        res.ready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        clock_ms = 48'd1000;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: empty table, create errors, wide times, saturation, expiry.
        send_word(OP_QUERY, 48'd0, 32'd0, 6'd0);
        send_word(OP_CANCEL, 48'd0, 32'd0, 6'd63);
        send_word(OP_NEXT_WAIT, 48'd0, 32'd0, 6'd0);
        send_word(OP_PROCESS, 48'd0, 32'd0, 6'd0);
        send_word(OP_CREATE_ONE, 48'd0, 32'd0, 6'd0);
        send_word(OP_CREATE_REP, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 6'h3F);
        send_word(OP_NEXT_WAIT, 48'd0, 32'd0, 6'd0);
        send_word(OP_CREATE_ONE, 48'd0, 32'd5, 6'd0);
        send_word(OP_CREATE_REP, 48'd0, 32'd1, 6'd0);
        send_word(OP_QUERY, 48'd0, 32'd0, 6'd1);
        send_word(OP_NEXT_WAIT, 48'd0, 32'd0, 6'd0);
        send_word(OP_NEXT_WAIT, 48'd2, 32'd0, 6'd0);
        send_word(OP_PROCESS, 48'd1, 32'd0, 6'd0);
        send_word(OP_PROCESS, 48'd5, 32'd0, 6'd0);
        send_word(OP_PROCESS, 48'd5, 32'd0, 6'd0);
        send_word(OP_QUERY, 48'd5, 32'd0, 6'd1);
        send_word(OP_CANCEL, 48'd5, 32'd0, 6'd2);
        send_word(OP_CANCEL, 48'd5, 32'd0, 6'd0);
        send_word(OP_CANCEL, 48'd5, 32'd0, 6'd0);
        send_word(3'd6, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 6'h3F);
        send_word(3'd7, 48'd0, 32'd0, 6'd0);
        send_word(OP_PROCESS, 48'hFFFF_FFFF_FFFF, 32'd0, 6'd0);

        // Random part in three idling phases.
        send_idle_pct = 36;
        recv_stall_pct = 73;
        random_phase(RANDOM_WORDS / 3);
        send_idle_pct = 73;
        recv_stall_pct = 36;
        random_phase(RANDOM_WORDS / 3);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        random_phase(RANDOM_WORDS / 3);
        cmd.valid <= 1'b0;

        // Drain and let the unit settle.
        while (results_pending != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);

        if (mismatch_count == 0 && results_pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
